/* hdl/slt_pkg.sv */
// Shared types and codes for the sorted lifetime timer queue.
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned ResW   = 16;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned CountW = 5;

  // Request codes
  typedef enum logic [ReqW-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_EXPIRE = 2'd2
  } req_e;

  // One table entry
  typedef struct packed {
    logic [TimeW-1:0] lifetime;
    logic [ResW-1:0]  resource;
  } entry_t;

  // Compare unit results
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage : slt_pkg

`default_nettype wire

/* hdl/slt_if.sv */
// Request and response channel interfaces of the timer queue.
`timescale 1ns / 1ps
`default_nettype none

interface slt_req_if;
  logic                                valid;
  logic                                ready;
  logic [slt_pkg::ReqW-1:0]            req_type;
  logic [slt_pkg::TimeW-1:0]           time_value;
  logic [slt_pkg::ResW-1:0]            resource_id;

  modport source (output valid, req_type, time_value, resource_id, input ready);
  modport sink   (input valid, req_type, time_value, resource_id, output ready);
endinterface : slt_req_if

interface slt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                removed_any;
  logic                                insert_rejected;
  logic [slt_pkg::TimeW-1:0]           earliest_time;
  logic [slt_pkg::CountW-1:0]          entry_count;

  modport source (output valid, removed_any, insert_rejected, earliest_time, entry_count,
                  input ready);
  modport sink   (input valid, removed_any, insert_rejected, earliest_time, entry_count,
                  output ready);
endinterface : slt_rsp_if

`default_nettype wire

/* hdl/slt_cmp.sv */
// Shared lifetime comparator used by every table pass.
`timescale 1ns / 1ps
`default_nettype none

module slt_cmp (
  input  wire logic [slt_pkg::TimeW-1:0] a_i,
  input  wire logic [slt_pkg::TimeW-1:0] b_i,
  output slt_pkg::cmp_t                  res_o
);

  // Compare entry lifetime against the request key
  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule : slt_cmp

`default_nettype wire

/* hdl/slt_table.sv */
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module slt_table #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrW-1:0]     waddr_i,
  input  wire slt_pkg::entry_t      wdata_i,
  input  wire logic [AddrW-1:0]     raddr_i,
  output slt_pkg::entry_t           rdata_o
);

  slt_pkg::entry_t mem_q [Depth];
  slt_pkg::entry_t rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : slt_table

`default_nettype wire

/* hdl/sorted_lifetime_timer_queue.sv */
// Top level: sequencer that walks the sorted entry table through one comparator.
//
//   channel | dir | words                                   | handshake
//   req_i   | in  | req_type, time_value, resource_id       | valid/ready
//   rsp_o   | out | removed_any, insert_rejected,           | valid/ready
//           |     | earliest_time, entry_count              |
//
// Each entry visited takes a table read, then a compare and write back.
// Insert walks down from the top held entry, shifting entries up until its slot is
// found; delete and expire walk every held entry; a full-table insert or an unused
// code goes straight to S_DONE.
// With one table read port and one shared comparator, entries are visited singly.
// Reset empties the table at once; no clearing pass is needed.
// A finished word waits in the output register while the next request runs.
`timescale 1ns / 1ps
`default_nettype none

module sorted_lifetime_timer_queue #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  slt_req_if.sink   req_i,
  slt_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TimeW = slt_pkg::TimeW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EVAL = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  slt_pkg::req_e      op_q, op_d;
  logic [TimeW-1:0]   key_q, key_d;
  logic [slt_pkg::ResW-1:0] rid_q, rid_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    wr_q, wr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [TimeW-1:0]   head_q, head_d;
  logic               removed_q, removed_d;
  logic               rejected_q, rejected_d;

  logic               rsp_valid_q, rsp_valid_d;
  logic               rsp_removed_q, rsp_rejected_q;
  logic [TimeW-1:0]   rsp_earliest_q;
  logic [slt_pkg::CountW-1:0] rsp_count_q;

  logic               tbl_we;
  logic [AddrW-1:0]   tbl_waddr;
  slt_pkg::entry_t    tbl_wdata;
  logic [AddrW-1:0]   tbl_raddr;
  slt_pkg::entry_t    tbl_rdata;
  slt_pkg::entry_t    new_entry;
  slt_pkg::cmp_t      cmp;
  logic [CntW-1:0]    idx_m1;
  logic [CntW-1:0]    count_p1;
  logic [CntW+slt_pkg::CountW-1:0] count_ext;
  logic               rsp_load;
  logic               req_fire;

  slt_table #(
    .Depth (TABLE_DEPTH),
    .AddrW (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  slt_cmp u_cmp (
    .a_i   (tbl_rdata.lifetime),
    .b_i   (key_q),
    .res_o (cmp)
  );

  assign new_entry.lifetime = key_q;
  assign new_entry.resource = rid_q;
  assign idx_m1   = idx_q - 1'b1;
  assign count_p1 = count_q + 1'b1;
  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  assign req_i.ready = (state_q == S_IDLE);

  // Sequence one request over the table
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    rid_d      = rid_q;
    idx_d      = idx_q;
    wr_d       = wr_q;
    count_d    = count_q;
    removed_d  = removed_q;
    rejected_d = rejected_q;
    tbl_we     = 1'b0;
    tbl_waddr  = '0;
    tbl_wdata  = new_entry;
    tbl_raddr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          key_d      = req_i.time_value;
          rid_d      = req_i.resource_id;
          removed_d  = 1'b0;
          rejected_d = 1'b0;
          wr_d       = '0;
          unique case (req_i.req_type)
            slt_pkg::REQ_INSERT: begin
              op_d = slt_pkg::REQ_INSERT;
              idx_d = count_q;
              if (count_q == CntW'(TABLE_DEPTH)) begin
                rejected_d = 1'b1;
                state_d    = S_DONE;
              end else begin
                state_d = S_READ;
              end
            end
            slt_pkg::REQ_DELETE: begin
              op_d    = slt_pkg::REQ_DELETE;
              idx_d   = '0;
              state_d = S_READ;
            end
            slt_pkg::REQ_EXPIRE: begin
              op_d    = slt_pkg::REQ_EXPIRE;
              idx_d   = '0;
              state_d = S_READ;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        if (op_q == slt_pkg::REQ_INSERT) begin
          // Bottom of the table reached: place the new entry first
          if (idx_q == '0) begin
            tbl_we    = 1'b1;
            tbl_waddr = '0;
            tbl_wdata = new_entry;
            count_d   = count_p1;
            state_d   = S_DONE;
          end else begin
            tbl_raddr = idx_m1[AddrW-1:0];
            state_d   = S_EVAL;
          end
        end else begin
          // End of the held entries: commit the compacted count
          if (idx_q == count_q) begin
            count_d = wr_q;
            state_d = S_DONE;
          end else begin
            tbl_raddr = idx_q[AddrW-1:0];
            state_d   = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        if (op_q == slt_pkg::REQ_INSERT) begin
          if (cmp.lt) begin
            // Smaller entry found below: new entry goes just above it
            tbl_we    = 1'b1;
            tbl_waddr = idx_q[AddrW-1:0];
            tbl_wdata = new_entry;
            count_d   = count_p1;
            state_d   = S_DONE;
          end else begin
            // Shift this entry up one slot
            tbl_we    = 1'b1;
            tbl_waddr = idx_q[AddrW-1:0];
            tbl_wdata = tbl_rdata;
            idx_d     = idx_m1;
            state_d   = S_READ;
          end
        end else begin
          if (cmp.eq || ((op_q == slt_pkg::REQ_EXPIRE) && cmp.lt)) begin
            removed_d = 1'b1;
          end else begin
            // Keep: copy down to the write pointer
            tbl_we    = 1'b1;
            tbl_waddr = wr_q[AddrW-1:0];
            tbl_wdata = tbl_rdata;
            wr_d      = wr_q + 1'b1;
          end
          idx_d   = idx_q + 1'b1;
          state_d = S_READ;
        end
      end

      S_DONE: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Track the lifetime at the head of the table
  always_comb begin
    head_d = head_q;
    if (tbl_we && (tbl_waddr == '0)) begin
      head_d = tbl_wdata.lifetime;
    end
  end

  assign count_ext   = {{slt_pkg::CountW{1'b0}}, count_q};
  assign rsp_valid_d = rsp_load ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Request working registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    rid_q      <= rid_d;
    idx_q      <= idx_d;
    wr_q       <= wr_d;
    head_q     <= head_d;
    removed_q  <= removed_d;
    rejected_q <= rejected_d;
  end

  // Hold the finished word until taken
  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_removed_q  <= removed_q;
      rsp_rejected_q <= rejected_q;
      rsp_earliest_q <= (count_q != '0) ? head_q : '0;
      rsp_count_q    <= count_ext[slt_pkg::CountW-1:0];
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.removed_any     = rsp_removed_q;
  assign rsp_o.insert_rejected = rsp_rejected_q;
  assign rsp_o.earliest_time   = rsp_earliest_q;
  assign rsp_o.entry_count     = rsp_count_q;

endmodule : sorted_lifetime_timer_queue

`default_nettype wire
